// ===== rtl/integer_to_radix_digits_macros.svh =====
// Assertion macros for the integer_to_radix_digits block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`ifndef SYNTH
`define ITRD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
	else $error(msg);
`define ITRD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
	else $error(msg);
`else
`define ITRD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ITRD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/itrd_pkg.sv =====
// Shared constants, codes and types for the integer_to_radix_digits block.
// No dependencies.
package itrd_pkg;

	localparam int MAX_BASE   = 16;
	localparam int MAX_DIGITS = 32;
	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 8;
	localparam int LEN_W      = 5;
	localparam int ALPHA_AW   = $clog2(MAX_BASE);
	localparam int DIGIT_W    = ALPHA_AW;
	localparam int BUF_AW     = $clog2(MAX_DIGITS);
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int DIV_BITS   = 8;
	localparam int DIV_PASSES = VALUE_W / DIV_BITS;
	localparam int PASS_W     = $clog2(DIV_PASSES);
	localparam int SEEN_AW    = CHAR_W - 1;
	localparam int SEEN_W     = 2 ** SEEN_AW;

	localparam logic [LEN_W-1:0]  BASE_LEN_RESET = LEN_W'(10);
	localparam logic [LEN_W-1:0]  MIN_LEN        = LEN_W'(2);
	localparam logic [LEN_W-1:0]  MAX_LEN        = LEN_W'(MAX_BASE);
	localparam logic [CHAR_W-1:0] CHAR_PLUS      = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS     = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NUL       = 8'h00;
	localparam logic [CHAR_W-1:0] PRINT_LOW      = 8'd32;
	localparam logic [CHAR_W-1:0] PRINT_HIGH     = 8'd126;

	typedef enum logic {
		CMD_LOAD    = 1'b0,
		CMD_CONVERT = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_SIGN,
		ST_FETCH,
		ST_PUT,
		ST_ERR
	} state_t;

	typedef struct packed {
		logic                done;
		logic [VALUE_W-1:0]  quotient;
		logic [DIGIT_W-1:0]  remainder;
	} div_stat_t;

endpackage

// ===== rtl/itrd_if.sv =====
// Valid/ready channel interfaces for the command and character words.
// Depends on itrd_pkg.
interface itrd_item_if;
	logic                              valid;
	logic                              ready;
	logic                              command;
	logic [itrd_pkg::ALPHA_AW-1:0]     entry_index;
	logic [itrd_pkg::CHAR_W-1:0]       entry_char;
	logic signed [itrd_pkg::VALUE_W-1:0] value;

	modport source(output valid, command, entry_index, entry_char, value, input ready);
	modport sink(input valid, command, entry_index, entry_char, value, output ready);
endinterface

interface itrd_result_if;
	logic                          valid;
	logic                          ready;
	logic [itrd_pkg::CHAR_W-1:0]   out_char;
	logic                          is_last;
	logic                          base_error;

	modport source(output valid, out_char, is_last, base_error, input ready);
	modport sink(input valid, out_char, is_last, base_error, output ready);
endinterface

// ===== rtl/integer_to_radix_digits.sv =====
// Sequence: the check phase reads the base_length alphabet entries, the divider makes each
// digit in 4 passes of 8 bits, negatives get a minus sign, and each digit character
// is fetched from the alphabet RAM, then put. One word is taken at a time; output stalls
// hold sign, digit and error words. Load words write the alphabet; a bad length is an error.
// Reset: sequencer idle, base_length 10, output register empty; alphabet and digit store
// are not cleared. Depends on itrd_pkg, itrd_if, itrd_divider and the macro header.
`include "integer_to_radix_digits_macros.svh"

module integer_to_radix_digits (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [itrd_pkg::LEN_W-1:0]   cfg_wdata,
	itrd_item_if.sink                    item,
	itrd_result_if.source                result
);

	itrd_pkg::state_t state_q, state_d;

	logic [itrd_pkg::LEN_W-1:0]    base_len_q;
	logic [itrd_pkg::LEN_W-1:0]    len_m1;
	logic [itrd_pkg::ALPHA_AW-1:0] idx_q;
	logic [itrd_pkg::CNT_W-1:0]    cnt_q;
	logic [itrd_pkg::CNT_W-1:0]    cnt_m1;
	logic [itrd_pkg::CNT_W-1:0]    cnt_inc;
	logic [itrd_pkg::VALUE_W-1:0]  raw;
	logic [itrd_pkg::VALUE_W-1:0]  mag_q;
	logic                          neg_q;
	logic [itrd_pkg::SEEN_W-1:0]   seen_q;

	logic [itrd_pkg::CHAR_W-1:0]   alpha_mem [itrd_pkg::MAX_BASE];
	logic [itrd_pkg::CHAR_W-1:0]   alpha_rd_q;
	logic                          alpha_re;
	logic [itrd_pkg::ALPHA_AW-1:0] alpha_ra;

	logic [itrd_pkg::DIGIT_W-1:0]  buf_q [itrd_pkg::MAX_DIGITS];
	logic [itrd_pkg::DIGIT_W-1:0]  buf_rd;

	logic                          item_acc;
	logic                          conv_acc;
	logic                          len_bad;
	logic                          chr_bad;
	logic                          chk_end;
	logic                          last_digit;
	logic                          out_free;

	logic                          div_start;
	logic [itrd_pkg::VALUE_W-1:0]  div_dividend;
	itrd_pkg::div_stat_t           div_st;

	logic                          out_valid_q;
	logic [itrd_pkg::CHAR_W-1:0]   out_char_q;
	logic                          out_last_q;
	logic                          out_err_q;
	logic                          out_ld;
	logic [itrd_pkg::CHAR_W-1:0]   out_char_d;
	logic                          out_last_d;
	logic                          out_err_d;

	itrd_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.radix    (base_len_q),
		.stat     (div_st)
	);

	assign item.ready = (state_q == itrd_pkg::ST_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign conv_acc   = item_acc && (item.command == itrd_pkg::CMD_CONVERT);
	assign raw        = item.value;

	assign len_m1     = base_len_q - itrd_pkg::LEN_W'(1);
	assign len_bad    = (base_len_q < itrd_pkg::MIN_LEN) || (base_len_q > itrd_pkg::MAX_LEN);
	assign chr_bad    = (alpha_rd_q == itrd_pkg::CHAR_PLUS) ||
	                    (alpha_rd_q == itrd_pkg::CHAR_MINUS) ||
	                    (alpha_rd_q < itrd_pkg::PRINT_LOW) ||
	                    (alpha_rd_q > itrd_pkg::PRINT_HIGH) ||
	                    seen_q[alpha_rd_q[itrd_pkg::SEEN_AW-1:0]];
	assign chk_end    = (idx_q == len_m1[itrd_pkg::ALPHA_AW-1:0]);

	assign cnt_m1     = cnt_q - itrd_pkg::CNT_W'(1);
	assign cnt_inc    = cnt_q + itrd_pkg::CNT_W'(1);
	assign buf_rd     = buf_q[cnt_m1[itrd_pkg::BUF_AW-1:0]];
	assign last_digit = (cnt_q == itrd_pkg::CNT_W'(1));
	assign out_free   = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itrd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		alpha_re     = 1'b0;
		alpha_ra     = '0;
		div_start    = 1'b0;
		div_dividend = div_st.quotient;
		out_ld       = 1'b0;
		out_char_d   = itrd_pkg::CHAR_NUL;
		out_last_d   = 1'b0;
		out_err_d    = 1'b0;
		unique case (state_q)
			itrd_pkg::ST_IDLE: begin
				if (conv_acc) begin
					if (len_bad) begin
						state_d = itrd_pkg::ST_ERR;
					end else begin
						alpha_re = 1'b1;
						state_d  = itrd_pkg::ST_CHECK;
					end
				end
			end
			itrd_pkg::ST_CHECK: begin
				alpha_re = 1'b1;
				alpha_ra = idx_q + itrd_pkg::ALPHA_AW'(1);
				if (chr_bad) begin
					state_d = itrd_pkg::ST_ERR;
				end else if (chk_end) begin
					div_start    = 1'b1;
					div_dividend = mag_q;
					state_d      = itrd_pkg::ST_DIV;
				end
			end
			itrd_pkg::ST_DIV: begin
				if (div_st.done) begin
					if ((div_st.quotient == '0) ||
					    (cnt_inc == itrd_pkg::CNT_W'(itrd_pkg::MAX_DIGITS))) begin
						state_d = neg_q ? itrd_pkg::ST_SIGN : itrd_pkg::ST_FETCH;
					end else begin
						div_start = 1'b1;
					end
				end
			end
			itrd_pkg::ST_SIGN: begin
				if (out_free) begin
					out_ld     = 1'b1;
					out_char_d = itrd_pkg::CHAR_MINUS;
					state_d    = itrd_pkg::ST_FETCH;
				end
			end
			itrd_pkg::ST_FETCH: begin
				alpha_re = 1'b1;
				alpha_ra = buf_rd;
				state_d  = itrd_pkg::ST_PUT;
			end
			itrd_pkg::ST_PUT: begin
				if (out_free) begin
					out_ld     = 1'b1;
					out_char_d = alpha_rd_q;
					out_last_d = last_digit;
					state_d    = last_digit ? itrd_pkg::ST_IDLE : itrd_pkg::ST_FETCH;
				end
			end
			itrd_pkg::ST_ERR: begin
				if (out_free) begin
					out_ld     = 1'b1;
					out_last_d = 1'b1;
					out_err_d  = 1'b1;
					state_d    = itrd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = itrd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_len_q  <= itrd_pkg::BASE_LEN_RESET;
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_len_q <= cfg_wdata;
			end
			if (conv_acc) begin
				idx_q <= '0;
			end else if (state_q == itrd_pkg::ST_CHECK) begin
				idx_q <= idx_q + itrd_pkg::ALPHA_AW'(1);
			end
			if (conv_acc) begin
				cnt_q <= '0;
			end else if (state_q == itrd_pkg::ST_DIV && div_st.done) begin
				cnt_q <= cnt_inc;
			end else if (state_q == itrd_pkg::ST_PUT && out_free) begin
				cnt_q <= cnt_m1;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// alphabet RAM: one write, one registered read
	always_ff @(posedge clk) begin
		if (item_acc && item.command == itrd_pkg::CMD_LOAD) begin
			alpha_mem[item.entry_index] <= item.entry_char;
		end
		if (alpha_re) begin
			alpha_rd_q <= alpha_mem[alpha_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (conv_acc) begin
			neg_q  <= raw[itrd_pkg::VALUE_W-1];
			mag_q  <= raw[itrd_pkg::VALUE_W-1] ? (itrd_pkg::VALUE_W'(0) - raw) : raw;
			seen_q <= '0;
		end else if (state_q == itrd_pkg::ST_CHECK) begin
			seen_q[alpha_rd_q[itrd_pkg::SEEN_AW-1:0]] <= 1'b1;
		end
		if (state_q == itrd_pkg::ST_DIV && div_st.done) begin
			buf_q[cnt_q[itrd_pkg::BUF_AW-1:0]] <= div_st.remainder;
		end
		if (out_ld) begin
			out_char_q <= out_char_d;
			out_last_q <= out_last_d;
			out_err_q  <= out_err_d;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_char   = out_char_q;
	assign result.is_last    = out_last_q;
	assign result.base_error = out_err_q;

	`ITRD_ASSERT_IMP(a_err_is_last, clk, arst_n, out_valid_q && out_err_q, out_last_q,
		"base error word not marked last")
	`ITRD_ASSERT_IMP(a_emit_cnt_nonzero, clk, arst_n,
		(state_q == itrd_pkg::ST_FETCH) || (state_q == itrd_pkg::ST_PUT), cnt_q != '0,
		"digit emission with empty digit store")
	`ITRD_ASSERT_IMP(a_div_done_in_div, clk, arst_n, div_st.done,
		state_q == itrd_pkg::ST_DIV, "divider finished outside division phase")

endmodule

// ===== rtl/itrd_divider.sv =====
// Iterative divider: 32-bit dividend by a small radix, 8 quotient bits per cycle.
// Depends on itrd_pkg.
module itrd_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [itrd_pkg::VALUE_W-1:0]   dividend,
	input  logic [itrd_pkg::LEN_W-1:0]     radix,
	output itrd_pkg::div_stat_t            stat
);

	logic [itrd_pkg::VALUE_W-1:0] dq_q;
	logic [itrd_pkg::DIGIT_W-1:0] rem_q;
	logic [itrd_pkg::PASS_W-1:0]  pass_q;
	logic                         busy_q;
	logic                         done_q;
	logic [itrd_pkg::VALUE_W-1:0] dq_d;
	logic [itrd_pkg::DIGIT_W-1:0] rem_d;

	// restoring steps, remainder stays below radix
	always_comb begin
		logic [itrd_pkg::LEN_W-1:0] t;
		logic                       qb;
		rem_d = rem_q;
		dq_d  = dq_q;
		for (int i = 0; i < itrd_pkg::DIV_BITS; i++) begin
			t  = {rem_d, dq_d[itrd_pkg::VALUE_W-1]};
			qb = (t >= radix);
			if (qb) begin
				t = t - radix;
			end
			rem_d = t[itrd_pkg::DIGIT_W-1:0];
			dq_d  = {dq_d[itrd_pkg::VALUE_W-2:0], qb};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pass_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			pass_q <= '0;
		end else if (busy_q) begin
			pass_q <= pass_q + itrd_pkg::PASS_W'(1);
			if (pass_q == itrd_pkg::PASS_W'(itrd_pkg::DIV_PASSES - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= dq_d;
			rem_q <= rem_d;
		end
	end

	assign stat.done      = done_q;
	assign stat.quotient  = dq_q;
	assign stat.remainder = rem_q;

endmodule
